>>> rtl/scfd_pkg.sv
package scfd_pkg;

    // Geometry of the directory
    localparam int ROWS_PER_STRIP = 16;
    localparam int MAX_STRIPS     = 4096;
    localparam int MAX_SLOTS      = 64;

    localparam int ROW_W     = 16;
    localparam int COL_W     = 16;
    localparam int ROW_LO_W  = $clog2(ROWS_PER_STRIP);
    localparam int STRIP_W   = $clog2(MAX_STRIPS);
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int SCNT_W    = $clog2(MAX_SLOTS + 1);
    localparam int DIR_W     = SLOT_W + 1;

    // Configuration register widths
    localparam int WIDTH_W   = 16;
    localparam int BPS_W     = 5;
    localparam int SLOTS_W   = 7;

    // Offset arithmetic
    localparam int LIN_W     = ROW_LO_W + WIDTH_W + 1;
    localparam int PROD_W    = LIN_W + BPS_W;
    localparam int OFFSET_W  = 24;

    // Stream payloads
    localparam int S_DATA_W  = ROW_W + COL_W;
    localparam int M_FIELD_W = 1 + SLOT_W + STRIP_W + 1 + STRIP_W + OFFSET_W;
    localparam int M_DATA_W  = ((M_FIELD_W + 7) / 8) * 8;

    // APB register map
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH      = 2'd0,
        REG_BYTES_PER_SAMPLE = 2'd1,
        REG_SLOTS_IN_USE     = 2'd2
    } reg_idx_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;   // write one entry of the reset sweep
        logic accept;     // latch request, issue directory reads
        logic lookup;     // resolve hit/miss, install new strip
        logic evict;      // drop the displaced strip from the directory
        logic finish;     // load the result register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last; // sweep is at its final entry
        logic evict_need; // miss lands on an occupied slot
        logic out_free;   // result register can take a new result
    } sts_t;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_EVICT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Slot count after clamping to 1..MAX_SLOTS
    function automatic logic [SCNT_W-1:0] eff_slots(input logic [SLOTS_W-1:0] n);
        logic [SCNT_W-1:0] r;
        if (n == '0) begin
            r = SCNT_W'(1);
        end else if (SCNT_W'(n) > SCNT_W'(MAX_SLOTS)) begin
            r = SCNT_W'(MAX_SLOTS);
        end else begin
            r = SCNT_W'(n);
        end
        return r;
    endfunction

endpackage

>>> rtl/strip_cache_fifo_directory_top.sv
// Strip cache directory: each request names a pixel by row and column; the
// strip (row / 16, wrapped to 4096 strips) is looked up in a residency table.
// On a hit the holding slot is returned; on a miss the next slot in
// round-robin order over the first slots_in_use slots is taken, the strip it
// held is reported as evicted, and a fetch of the new strip is requested.
// Every result also carries the byte offset of the sample inside the slot,
// ((row % 16) * image_width + column) * bytes_per_sample, wrapped to 24 bits.
// Sequence: after reset the directory memory is swept clear with s_tready low
// (APB writes are taken throughout). A request then steps through accept,
// lookup and result load, plus an evict step when a miss evicts a strip, set
// by the single write port of the strip directory memory, which needs one
// write to install the new strip and one to drop the old one. The result sits
// in an output register, so the next request is taken while it waits. The user
// is to write configuration only while no request is in flight; not enforced.
module strip_cache_fifo_directory_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scfd_pkg::S_DATA_W-1:0]  s_tdata,   // pixel_row[15:0], pixel_column[31:16]
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scfd_pkg::M_DATA_W-1:0]  m_tdata,   // hit[0], slot[6:1], fetch_strip[18:7],
                                                      // evict_valid[19], evicted_strip[31:20],
                                                      // byte_offset[55:32]
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scfd_pkg::PADDR_W-1:0]   paddr,
    input  logic [scfd_pkg::PDATA_W-1:0]   pwdata,
    output logic [scfd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import scfd_pkg::*;

    logic [WIDTH_W-1:0] width_reg;
    logic [BPS_W-1:0]   bps_reg;
    logic [SLOTS_W-1:0] slots_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;
    cmd_t               cmd;
    sts_t               sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    // Register file; writes to unmapped addresses are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_W'(1024);
            bps_reg   <= BPS_W'(1);
            slots_reg <= SLOTS_W'(64);
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:      width_reg <= pwdata[WIDTH_W-1:0];
                REG_BYTES_PER_SAMPLE: bps_reg   <= pwdata[BPS_W-1:0];
                REG_SLOTS_IN_USE:     slots_reg <= pwdata[SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:      prdata = PDATA_W'(width_reg);
            REG_BYTES_PER_SAMPLE: prdata = PDATA_W'(bps_reg);
            REG_SLOTS_IN_USE:     prdata = PDATA_W'(slots_reg);
            default:              prdata = '0;
        endcase
    end

    // Sequencer: reset sweep, then accept / lookup / evict / result
    scfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Directory memories, round-robin pointer, offset multiplier, result reg
    scfd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_width (width_reg),
        .cfg_bps   (bps_reg),
        .cfg_slots (slots_reg),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/scfd_ctrl.sv
module scfd_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  scfd_pkg::sts_t  sts,
    output scfd_pkg::cmd_t  cmd
);
    import scfd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = sts.evict_need ? ST_EVICT : ST_FINISH;
            end
            ST_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/scfd_datapath.sv
module scfd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [scfd_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [scfd_pkg::WIDTH_W-1:0]      cfg_width,
    input  logic [scfd_pkg::BPS_W-1:0]        cfg_bps,
    input  logic [scfd_pkg::SLOTS_W-1:0]      cfg_slots,
    input  scfd_pkg::cmd_t                    cmd,
    output scfd_pkg::sts_t                    sts,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scfd_pkg::M_DATA_W-1:0]     m_tdata
);
    import scfd_pkg::*;

    // Directory memories
    logic [DIR_W-1:0]   dir_mem [MAX_STRIPS];  // {resident, slot} per strip
    logic [STRIP_W-1:0] s2s_mem [MAX_SLOTS];   // strip held by each slot

    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    in_col;
    logic [STRIP_W-1:0]  in_strip;
    logic [SCNT_W-1:0]   n_eff;
    logic [SLOT_W-1:0]   cand;
    logic [SCNT_W-1:0]   cand_inc;

    logic [ROW_LO_W-1:0] row_lo_reg;
    logic [COL_W-1:0]    col_reg;
    logic [STRIP_W-1:0]  strip_reg;
    logic [SLOT_W-1:0]   cand_reg;
    logic [DIR_W-1:0]    dir_rd_reg;
    logic [STRIP_W-1:0]  s2s_rd_reg;
    logic [MAX_SLOTS-1:0] occ_reg;
    logic [SLOT_W-1:0]   next_slot_reg;
    logic [STRIP_W-1:0]  clr_cnt_reg;

    logic                hit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                evict_reg;
    logic [STRIP_W-1:0]  old_reg;
    logic [LIN_W-1:0]    lin_reg;
    logic [LIN_W-1:0]    lin_next;
    logic [PROD_W-1:0]   prod;

    logic                miss;
    logic                dir_we;
    logic [STRIP_W-1:0]  dir_waddr;
    logic [DIR_W-1:0]    dir_wdata;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    assign in_row   = s_tdata[ROW_W-1:0];
    assign in_col   = s_tdata[ROW_W +: COL_W];
    assign in_strip = STRIP_W'(in_row >> ROW_LO_W);

    // Round-robin pointer falls back to slot 0 when past the active count
    assign n_eff    = eff_slots(cfg_slots);
    assign cand     = (SCNT_W'(next_slot_reg) >= n_eff) ? '0 : next_slot_reg;
    assign cand_inc = SCNT_W'(cand_reg) + SCNT_W'(1);

    assign miss     = !dir_rd_reg[DIR_W-1];

    assign sts.clear_last = (clr_cnt_reg == STRIP_W'(MAX_STRIPS - 1));
    assign sts.evict_need = miss && occ_reg[cand_reg];
    assign sts.out_free   = !m_valid_reg || m_tready;

    // Directory write port: reset sweep, install on miss, drop on evict
    always_comb begin
        dir_we    = 1'b0;
        dir_waddr = strip_reg;
        dir_wdata = '0;
        if (cmd.clear_wr) begin
            dir_we    = 1'b1;
            dir_waddr = clr_cnt_reg;
        end else if (cmd.lookup && miss) begin
            dir_we    = 1'b1;
            dir_wdata = {1'b1, cand_reg};
        end else if (cmd.evict) begin
            dir_we    = 1'b1;
            dir_waddr = old_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            dir_rd_reg <= dir_mem[in_strip];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lookup && miss) begin
            s2s_mem[cand_reg] <= strip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            s2s_rd_reg <= s2s_mem[cand];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg       <= '0;
            next_slot_reg <= '0;
            clr_cnt_reg   <= '0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + STRIP_W'(1);
            end
            if (cmd.lookup && miss) begin
                occ_reg[cand_reg] <= 1'b1;
                next_slot_reg     <= (cand_inc >= n_eff) ? '0 : cand_inc[SLOT_W-1:0];
            end
        end
    end

    // Request payload and lookup results
    assign lin_next = LIN_W'(row_lo_reg) * LIN_W'(cfg_width) + LIN_W'(col_reg);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_lo_reg <= in_row[ROW_LO_W-1:0];
            col_reg    <= in_col;
            strip_reg  <= in_strip;
            cand_reg   <= cand;
        end
        if (cmd.lookup) begin
            hit_reg   <= !miss;
            slot_reg  <= miss ? cand_reg : dir_rd_reg[SLOT_W-1:0];
            evict_reg <= miss && occ_reg[cand_reg];
            old_reg   <= s2s_rd_reg;
            lin_reg   <= lin_next;
        end
    end

    // Second multiply, then the result register
    assign prod = PROD_W'(lin_reg) * PROD_W'(cfg_bps);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= M_DATA_W'({prod[OFFSET_W-1:0],
                                     evict_reg ? old_reg : STRIP_W'(0),
                                     evict_reg,
                                     hit_reg ? STRIP_W'(0) : strip_reg,
                                     slot_reg,
                                     hit_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> sim/tb.sv
// Testbench for strip_cache_fifo_directory_top.
//
// Pixel requests go in on the s_ stream. Each accepted request runs through a
// local directory model: residency per strip, slot per strip, strip per slot,
// slot occupancy and the round-robin pointer. The model yields one expected
// lookup result, which is queued. Every result taken on the m_ stream is
// unpacked and compared field by field against the oldest queued entry.
// Configuration goes through APB, and only once the queue has drained.
//
// Test order:
//   - reset configuration: cold miss, hit, top strip, column past the width
//   - offset arithmetic: widest rows, large and zero sample sizes, 24-bit wrap
//   - slot count: zero acts as one, counts above 64 clamp, and a pointer left
//     past a reduced count falls back to slot 0
//   - random traffic over several settings: mostly requests drawn from a
//     working set of strips sized near the slot count, so that hits,
//     evictions and refills mix, plus some fully random requests
// Both sides draw a random per-request idle gap. Some stretches run
// with no gaps at all.
module tb;
    import scfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;  // covers the clear sweep plus ~600 worst-case requests
    localparam int SETTLE_CYCLES = 8;       // covers the evict path plus margin
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 80;

    // Field order mirrors m_tdata: the last member lands in bit 0.
    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [STRIP_W-1:0]  evicted_strip;
        logic                evict_valid;
        logic [STRIP_W-1:0]  fetch_strip;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
    } dir_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    strip_cache_fifo_directory_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Directory model state
    logic               strip_held [MAX_STRIPS];
    logic [SLOT_W-1:0]  strip_slot [MAX_STRIPS];
    logic [STRIP_W-1:0] slot_strip [MAX_SLOTS];
    logic               slot_busy  [MAX_SLOTS];
    logic [SLOT_W-1:0]  rr_ptr;

    // Shadow of the configuration registers
    logic [WIDTH_W-1:0] cfg_width;
    logic [BPS_W-1:0]   cfg_bps;
    logic [SLOTS_W-1:0] cfg_slots;

    dir_result_t pending_results [$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          send_idle   = 1'b1;
    bit          recv_idle   = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Run limit: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Clamp the slot register the way the directory uses it.
    function automatic int unsigned active_slots();
        int unsigned n;
        n = cfg_slots;
        if (n == 0) n = 1;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return n;
    endfunction

    // Model one pixel request: look up the strip, fill on a miss, update the directory.
    function automatic dir_result_t lookup_strip(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        dir_result_t       r;
        logic [STRIP_W-1:0] strip;
        logic [SLOT_W-1:0]  s;
        int unsigned       n;
        longint unsigned   lin;
        r = '0;
        strip = STRIP_W'((row / ROWS_PER_STRIP) % MAX_STRIPS);
        if (strip_held[strip]) begin
            r.hit  = 1'b1;
            r.slot = strip_slot[strip];
        end else begin
            n = active_slots();
            s = (rr_ptr >= n) ? '0 : rr_ptr;   // pointer left past a reduced count
            if (slot_busy[s]) begin
                r.evict_valid   = 1'b1;
                r.evicted_strip = slot_strip[s];
                strip_held[slot_strip[s]] = 1'b0;
            end
            strip_held[strip] = 1'b1;
            strip_slot[strip] = s;
            slot_strip[s]     = strip;
            slot_busy[s]      = 1'b1;
            r.slot            = s;
            r.fetch_strip     = strip;
            rr_ptr = (s + 1 >= n) ? '0 : SLOT_W'(s + 1);
        end
        lin = (64'(row % ROWS_PER_STRIP) * 64'(cfg_width) + 64'(col)) * 64'(cfg_bps);
        r.byte_offset = lin[OFFSET_W-1:0];
        return r;
    endfunction

    // Random strip that is not resident, so that a request for it must miss.
    function automatic logic [STRIP_W-1:0] pick_absent_strip();
        logic [STRIP_W-1:0] strip;
        strip = STRIP_W'($urandom);
        while (strip_held[strip]) strip = STRIP_W'($urandom);
        return strip;
    endfunction

    // Send one request. tvalid stays high across back-to-back requests, so it
    // is lowered only when a gap is drawn.
    task automatic send_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int gap;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(lookup_strip(row, col));
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup phase, then access phase; taken at the edge with pready high.
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        settle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk) penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_IMAGE_WIDTH:      cfg_width = value[WIDTH_W-1:0];
            REG_BYTES_PER_SAMPLE: cfg_bps   = value[BPS_W-1:0];
            REG_SLOTS_IN_USE:     cfg_slots = value[SLOTS_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result side: one stall draw per result, then hold tready until a result is taken.
    initial begin : result_sink
        int stall;
        forever begin
            stall = recv_idle ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each taken result with the oldest queued expectation.
    always @(posedge aclk) begin : result_check
        dir_result_t got;
        dir_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = dir_result_t'(m_tdata[M_FIELD_W-1:0]);
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit",           want.hit,           got.hit);
                check_field("slot",          want.slot,          got.slot);
                check_field("fetch_strip",   want.fetch_strip,   got.fetch_strip);
                check_field("evict_valid",   want.evict_valid,   got.evict_valid);
                check_field("evicted_strip", want.evicted_strip, got.evicted_strip);
                check_field("byte_offset",   want.byte_offset,   got.byte_offset);
            end
        end
    end

    // Reset configuration: 1024-pixel rows, 1 byte per sample, 64 slots.
    task automatic test_default_config();
        send_pixel(16'd0, 16'd0);          // cold miss into slot 0
        send_pixel(16'd15, 16'd1023);      // same strip: hit, last row and column
        send_pixel(16'hFFFF, 16'hFFFF);    // top strip, column past the width
        send_pixel(16'd16, 16'd5);         // next strip, next slot
        send_pixel(16'd7, 16'd512);        // back to strip 0: hit
    endtask

    // Offset arithmetic at the register extremes.
    task automatic test_offset_extremes();
        write_reg(REG_IMAGE_WIDTH, 32'd65535);
        write_reg(REG_BYTES_PER_SAMPLE, 32'd31);    // above 16, used as given
        send_pixel(16'd15, 16'hFFFF);               // largest product, wraps at 24 bits
        write_reg(REG_BYTES_PER_SAMPLE, 32'd16);
        send_pixel(16'd31, 16'hFFFE);
        write_reg(REG_BYTES_PER_SAMPLE, 32'd0);     // zero sample size: offset 0
        send_pixel(16'd14, 16'd1234);
        write_reg(REG_IMAGE_WIDTH, 32'd1);
        write_reg(REG_BYTES_PER_SAMPLE, 32'd1);
        send_pixel(16'd9, 16'd40);                  // column past a one-pixel row
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        send_pixel(16'd3, 16'd2);
    endtask

    // Slot count clamping and the pointer falling back to slot 0.
    task automatic test_slot_count_limits();
        logic [STRIP_W-1:0] strip;
        write_reg(REG_SLOTS_IN_USE, 32'd0);         // acts as a single slot
        repeat (2) begin
            strip = pick_absent_strip();
            send_pixel({strip, 4'($urandom)}, 16'($urandom));   // each miss evicts the last
        end
        send_pixel({strip, 4'($urandom)}, 16'd0);   // hit on the surviving strip
        write_reg(REG_SLOTS_IN_USE, 32'd127);       // clamps to 64
        repeat (3) send_pixel({pick_absent_strip(), 4'($urandom)}, 16'($urandom));
        write_reg(REG_SLOTS_IN_USE, 32'd64);
        while (rr_ptr < 4) send_pixel({pick_absent_strip(), 4'($urandom)}, 16'd7);
        write_reg(REG_SLOTS_IN_USE, 32'd3);         // pointer now past the count
        repeat (2) send_pixel({pick_absent_strip(), 4'($urandom)}, 16'd1);
    endtask

    // Random traffic over several settings. Most requests come from a working
    // set sized near the slot count, so hits and evictions both stay frequent.
    task automatic test_random_traffic();
        logic [STRIP_W-1:0] working_set [$];
        logic [WIDTH_W-1:0] img_width;
        logic [BPS_W-1:0]   bps;
        logic [SLOTS_W-1:0] slots;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        int                 ws_size;
        int                 phase;
        int                 i;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin img_width = 16'd1;     bps = 5'd1;  slots = 7'd1;  end
                1: begin img_width = 16'd65535; bps = 5'd16; slots = 7'd64; end
                2: begin img_width = 16'd640;   bps = 5'd3;  slots = 7'd8;  end
                default: begin
                    img_width = WIDTH_W'($urandom);
                    bps       = BPS_W'($urandom);
                    slots     = SLOTS_W'($urandom);
                end
            endcase
            write_reg(REG_IMAGE_WIDTH, 32'(img_width));
            write_reg(REG_BYTES_PER_SAMPLE, 32'(bps));
            write_reg(REG_SLOTS_IN_USE, 32'(slots));
            ws_size = $urandom_range(1, active_slots() + active_slots() / 2 + 2);
            working_set.delete();
            repeat (ws_size) working_set.push_back(STRIP_W'($urandom));
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // Switch idling on and off in stretches.
                if (i % 20 == 0) begin
                    send_idle = ($urandom_range(0, 2) != 0);
                    recv_idle = ($urandom_range(0, 2) != 0);
                end
                if ($urandom_range(0, 9) < 8) begin
                    row = {working_set[$urandom_range(0, ws_size - 1)], 4'($urandom)};
                    col = (img_width == 0) ? COL_W'($urandom)
                                           : COL_W'($urandom_range(0, img_width - 1));
                end else begin
                    row = ROW_W'($urandom);
                    col = COL_W'($urandom);
                end
                send_pixel(row, col);
            end
        end
    endtask

    initial begin : main
        int i;
        for (i = 0; i < MAX_STRIPS; i++) begin
            strip_held[i] = 1'b0;
            strip_slot[i] = '0;
        end
        for (i = 0; i < MAX_SLOTS; i++) begin
            slot_strip[i] = '0;
            slot_busy[i]  = 1'b0;
        end
        rr_ptr    = '0;
        cfg_width = 16'd1024;
        cfg_bps   = 5'd1;
        cfg_slots = 7'd64;

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // s_tready stays low through the clear sweep; the first request waits it out.
        test_default_config();
        test_offset_extremes();
        test_slot_count_limits();
        test_random_traffic();

        settle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
